/* hdl/alurf_pkg.sv */
// Shared types, register indexes, reset values and helpers for the ALU / register file block.
// No dependencies; used by every module under hdl.
`default_nettype none
package alurf_pkg;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_ADC     = 4'd1,
    OP_SUB     = 4'd2,
    OP_SBC     = 4'd3,
    OP_AND     = 4'd4,
    OP_XOR     = 4'd5,
    OP_BIT     = 4'd6,
    OP_SET     = 4'd7,
    OP_RES     = 4'd8,
    OP_RLC     = 4'd9,
    OP_RRC     = 4'd10,
    OP_COPY    = 4'd11,
    OP_LOADIMM = 4'd12,
    OP_INCHL   = 4'd13,
    OP_DECHL   = 4'd14,
    OP_NOP     = 4'd15
  } op_t;

  localparam logic [2:0] REG_A = 3'd0;
  localparam logic [2:0] REG_B = 3'd1;
  localparam logic [2:0] REG_C = 3'd2;
  localparam logic [2:0] REG_D = 3'd3;
  localparam logic [2:0] REG_E = 3'd4;
  localparam logic [2:0] REG_F = 3'd5;
  localparam logic [2:0] REG_H = 3'd6;
  localparam logic [2:0] REG_L = 3'd7;

  localparam logic [7:0] RST_A = 8'h01;
  localparam logic [7:0] RST_B = 8'h00;
  localparam logic [7:0] RST_C = 8'h13;
  localparam logic [7:0] RST_D = 8'h00;
  localparam logic [7:0] RST_E = 8'hD8;
  localparam logic [7:0] RST_F = 8'hB0;
  localparam logic [7:0] RST_H = 8'h01;
  localparam logic [7:0] RST_L = 8'h4D;

  localparam int IN_WIDTH  = 24;
  localparam int OUT_WIDTH = 32;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCOUNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic [7:0] e;
    logic [7:0] f;
    logic [7:0] h;
    logic [7:0] l;
  } regs_t;

  // flags from bit 3 down: zero, subtract, half-carry, carry
  typedef logic [3:0] flags_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] src;
    logic [2:0] dst;
    logic [7:0] mask;
    logic [7:0] imm;
    logic       wr_a;
    logic       wr_dst;
    logic       wr_hl;
    logic       wr_flags;
  } uop_t;

  function automatic logic [7:0] reg_get(input regs_t r, input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      REG_A:   v = r.a;
      REG_B:   v = r.b;
      REG_C:   v = r.c;
      REG_D:   v = r.d;
      REG_E:   v = r.e;
      REG_F:   v = r.f;
      REG_H:   v = r.h;
      REG_L:   v = r.l;
      default: v = r.a;
    endcase
    return v;
  endfunction

  function automatic regs_t reg_put(input regs_t r, input logic [2:0] idx,
                                    input logic [7:0] v);
    regs_t o;
    o = r;
    case (idx)
      REG_A:   o.a = v;
      REG_B:   o.b = v;
      REG_C:   o.c = v;
      REG_D:   o.d = v;
      REG_E:   o.e = v;
      REG_F:   o.f = v;
      REG_H:   o.h = v;
      REG_L:   o.l = v;
      default: o.a = v;
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

/* hdl/cpu_alu_register_file_top.sv */
// Top level of the 8-bit ALU and register file block.
// Depends on alurf_pkg, alurf_front, alurf_queue and alurf_back.
//
// Usage:
//   s_* channel carries one register-only instruction per word; m_* channel
//   returns exactly one result word per instruction, in order.
//   A word is moved on a rising edge with tvalid and tready both high.
//   An accepted instruction goes through the queue, then the registered
//   output word, before its result is presented on m_tvalid.
//   Throughput: one word per cycle while m_tready stays high, as the back
//   end reads and rewrites the register file in the same cycle, which lets
//   each instruction see the state left by the one before it.
//   A two-entry queue sits between decode and execute, and the output word
//   is registered, so a new instruction is accepted while a result waits.
//   When the receiver stalls, the output word holds, the queue fills, and
//   s_tready drops once the queue is full.
//   Reset (rst, synchronous, active high) loads the post-boot register
//   values A=01 B=00 C=13 D=00 E=D8 F=B0 H=01 L=4D and empties the queue.
`default_nettype none
module cpu_alu_register_file_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // func[3:0], src_reg[6:4], dst_reg[9:7], bit_index[12:10], immediate[20:13]
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // result_value[7:0], hl_value[23:8], flag_zero[24], flag_sub[25],
  // flag_half[26], flag_carry[27]
  output logic [31:0]      m_tdata
);

  alurf_pkg::uop_t push_uop;
  alurf_pkg::uop_t pop_uop;
  logic            q_push;
  logic            q_ready;
  logic            q_valid;
  logic            q_pop;

  alurf_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_uop    (push_uop)
  );

  alurf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_uop (push_uop),
    .ready    (q_ready),
    .valid    (q_valid),
    .pop_uop  (pop_uop),
    .pop      (q_pop)
  );

  alurf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_uop    (pop_uop),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

/* hdl/alurf_front.sv */
// Front end: unpacks the input word and decodes it into a micro-op for the queue.
// Depends on alurf_pkg.
`default_nettype none
module alurf_front (
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [alurf_pkg::IN_WIDTH-1:0] s_tdata,
  input  wire logic                           q_ready,
  output logic                                q_push,
  output alurf_pkg::uop_t                     q_uop
);

  alurf_pkg::op_t op;

  assign op       = alurf_pkg::op_t'(s_tdata[3:0]);
  assign s_tready = q_ready;
  assign q_push   = s_tvalid && q_ready;

  always_comb begin
    q_uop          = '0;
    q_uop.op       = op;
    q_uop.src      = s_tdata[6:4];
    q_uop.dst      = s_tdata[9:7];
    q_uop.mask     = 8'd1 << s_tdata[12:10];
    q_uop.imm      = s_tdata[20:13];
    case (op)
      alurf_pkg::OP_ADD, alurf_pkg::OP_ADC, alurf_pkg::OP_SUB,
      alurf_pkg::OP_SBC, alurf_pkg::OP_AND, alurf_pkg::OP_XOR: begin
        q_uop.wr_a     = 1'b1;
        q_uop.wr_flags = 1'b1;
      end
      alurf_pkg::OP_BIT: begin
        q_uop.wr_flags = 1'b1;
      end
      alurf_pkg::OP_RLC, alurf_pkg::OP_RRC: begin
        q_uop.wr_dst   = 1'b1;
        q_uop.wr_flags = 1'b1;
      end
      alurf_pkg::OP_SET, alurf_pkg::OP_RES, alurf_pkg::OP_COPY,
      alurf_pkg::OP_LOADIMM: begin
        q_uop.wr_dst = 1'b1;
      end
      alurf_pkg::OP_INCHL, alurf_pkg::OP_DECHL: begin
        q_uop.wr_hl = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* hdl/alurf_queue.sv */
// Short FIFO of decoded micro-ops between front and back ends.
// Depends on alurf_pkg.
`default_nettype none
module alurf_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire alurf_pkg::uop_t  push_uop,
  output logic                  ready,
  output logic                  valid,
  output alurf_pkg::uop_t       pop_uop,
  input  wire logic             pop
);

  alurf_pkg::uop_t                   mem [alurf_pkg::QDEPTH];
  logic [alurf_pkg::QPTR_W-1:0]      wr_ptr;
  logic [alurf_pkg::QPTR_W-1:0]      rd_ptr;
  logic [alurf_pkg::QCOUNT_W-1:0]    count;
  logic                              do_push;
  logic                              do_pop;

  assign ready   = count != alurf_pkg::QCOUNT_W'(alurf_pkg::QDEPTH);
  assign valid   = count != '0;
  assign do_push = push && ready;
  assign do_pop  = pop && valid;
  assign pop_uop = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_uop;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == alurf_pkg::QPTR_W'(alurf_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == alurf_pkg::QPTR_W'(alurf_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= alurf_pkg::QCOUNT_W'(alurf_pkg::QDEPTH))
    else $error("queue count over depth");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == alurf_pkg::QCOUNT_W'(alurf_pkg::QDEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count not decremented on pop");
`endif

endmodule
`default_nettype wire

/* hdl/alurf_back.sv */
// Back end: register file, combinational ALU and the output word register.
// Depends on alurf_pkg.
`default_nettype none
module alurf_back (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire alurf_pkg::uop_t                  q_uop,
  output logic                                  q_pop,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [alurf_pkg::OUT_WIDTH-1:0]       m_tdata
);

  alurf_pkg::regs_t   regs;
  alurf_pkg::regs_t   regs_next;
  alurf_pkg::flags_t  flags;
  logic [7:0]         a;
  logic [7:0]         s;
  logic [7:0]         d;
  logic               cin;
  logic               c;
  logic [8:0]         sum9;
  logic [4:0]         sum5;
  logic [8:0]         dif9;
  logic [4:0]         dif5;
  logic [15:0]        hl_new;
  logic [7:0]         val;
  logic               fire;
  logic [7:0]         out_value;
  logic [15:0]        out_hl;
  alurf_pkg::flags_t  out_flags;

  assign fire  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = fire;

  assign a    = regs.a;
  assign s    = alurf_pkg::reg_get(regs, q_uop.src);
  assign d    = alurf_pkg::reg_get(regs, q_uop.dst);
  assign cin  = regs.f[4];
  assign c    = (q_uop.op == alurf_pkg::OP_ADC || q_uop.op == alurf_pkg::OP_SBC) ? cin : 1'b0;
  assign sum9 = {1'b0, a} + {1'b0, s} + {8'd0, c};
  assign sum5 = {1'b0, a[3:0]} + {1'b0, s[3:0]} + {4'd0, c};
  assign dif9 = {1'b0, a} - {1'b0, s} - {8'd0, c};
  assign dif5 = {1'b0, a[3:0]} - {1'b0, s[3:0]} - {4'd0, c};
  assign hl_new = (q_uop.op == alurf_pkg::OP_INCHL) ? {regs.h, regs.l} + 16'd1
                                                    : {regs.h, regs.l} - 16'd1;

  always_comb begin
    val   = a;
    flags = '0;
    case (q_uop.op)
      alurf_pkg::OP_ADD, alurf_pkg::OP_ADC: begin
        val   = sum9[7:0];
        flags = {sum9[7:0] == 8'd0, 1'b0, sum5[4], sum9[8]};
      end
      alurf_pkg::OP_SUB, alurf_pkg::OP_SBC: begin
        val   = dif9[7:0];
        flags = {dif9[7:0] == 8'd0, 1'b1, dif5[4], dif9[8]};
      end
      alurf_pkg::OP_AND: begin
        val   = a & s;
        flags = {(a & s) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      alurf_pkg::OP_XOR: begin
        val   = a ^ s;
        flags = {(a ^ s) == 8'd0, 3'b000};
      end
      alurf_pkg::OP_BIT: begin
        val   = d;
        flags = {(d & q_uop.mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      alurf_pkg::OP_SET:     val = d | q_uop.mask;
      alurf_pkg::OP_RES:     val = d & ~q_uop.mask;
      alurf_pkg::OP_RLC: begin
        val   = {d[6:0], d[7]};
        flags = {d == 8'd0, 2'b00, d[7]};
      end
      alurf_pkg::OP_RRC: begin
        val   = {d[0], d[7:1]};
        flags = {d == 8'd0, 2'b00, d[0]};
      end
      alurf_pkg::OP_COPY:    val = s;
      alurf_pkg::OP_LOADIMM: val = q_uop.imm;
      alurf_pkg::OP_INCHL, alurf_pkg::OP_DECHL: val = hl_new[7:0];
      default:               val = a;
    endcase
  end

  always_comb begin
    regs_next = regs;
    if (q_uop.wr_a) begin
      regs_next.a = val;
    end
    if (q_uop.wr_dst) begin
      regs_next = alurf_pkg::reg_put(regs_next, q_uop.dst, val);
    end
    if (q_uop.wr_hl) begin
      regs_next.h = hl_new[15:8];
      regs_next.l = hl_new[7:0];
    end
    if (q_uop.wr_flags) begin
      regs_next.f = {flags, 4'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.a   <= alurf_pkg::RST_A;
      regs.b   <= alurf_pkg::RST_B;
      regs.c   <= alurf_pkg::RST_C;
      regs.d   <= alurf_pkg::RST_D;
      regs.e   <= alurf_pkg::RST_E;
      regs.f   <= alurf_pkg::RST_F;
      regs.h   <= alurf_pkg::RST_H;
      regs.l   <= alurf_pkg::RST_L;
      m_tvalid <= 1'b0;
    end else begin
      if (fire) begin
        regs     <= regs_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_value <= val;
      out_hl    <= {regs_next.h, regs_next.l};
      out_flags <= regs_next.f[7:4];
    end
  end

  // word: value[7:0], hl[23:8], zero[24], sub[25], half[26], carry[27]
  assign m_tdata = {4'h0, out_flags[0], out_flags[1], out_flags[2], out_flags[3],
                    out_hl, out_value};

`ifndef SYNTHESIS
  a_fire_valid: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("result not presented after execute");
  a_hold_regs: assert property (@(posedge clk) disable iff (rst)
    !$past(fire) |-> regs == $past(regs))
    else $error("register file changed without execute");
  a_flag_nibble: assert property (@(posedge clk) disable iff (rst)
    (fire && q_uop.wr_flags) |=> regs.f[3:0] == 4'h0)
    else $error("flag write left low nibble set");
`endif

endmodule
`default_nettype wire
